// ----- rtl/core/edid_block_parser_top_defines.svh -----
// Assertion macros for the EDID block parser.
// Used by edid_block_parser_top; expects i_clk and i_rst_n in scope.
`ifndef EDID_BLOCK_PARSER_TOP_DEFINES_SVH
`define EDID_BLOCK_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define EBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/edid_bp_pkg.sv -----
// Shared types, constants and helpers for the EDID block parser.
// No dependencies.
package edid_bp_pkg;

    localparam int BLOCK_LEN   = 128;
    localparam int DESC_LEN    = 18;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] POS_DESC_FIRST = 7'd54;
    localparam logic [6:0] POS_DESC_LAST  = 7'd125;
    localparam logic [6:0] POS_EXT_COUNT  = 7'd126;
    localparam logic [6:0] POS_CHECKSUM   = 7'd127;
    localparam logic [4:0] DESC_END_OFF   = 5'd17;

    localparam logic [7:0] DT_SERIAL = 8'hFF;
    localparam logic [7:0] DT_TEXT   = 8'hFE;
    localparam logic [7:0] DT_RANGE  = 8'hFD;
    localparam logic [7:0] DT_NAME   = 8'hFC;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Result tags
    localparam logic [4:0] TAG_HEADER_OK = 5'd0;
    localparam logic [4:0] TAG_SUM_OK    = 5'd1;
    localparam logic [4:0] TAG_VENDOR0   = 5'd2;
    localparam logic [4:0] TAG_VENDOR1   = 5'd3;
    localparam logic [4:0] TAG_VENDOR2   = 5'd4;
    localparam logic [4:0] TAG_PRODUCT   = 5'd5;
    localparam logic [4:0] TAG_SERIAL    = 5'd6;
    localparam logic [4:0] TAG_VERSION   = 5'd7;
    localparam logic [4:0] TAG_REVISION  = 5'd8;
    localparam logic [4:0] TAG_HSIZE     = 5'd9;
    localparam logic [4:0] TAG_VSIZE     = 5'd10;
    localparam logic [4:0] TAG_EXT_CNT   = 5'd11;
    localparam logic [4:0] TAG_KIND      = 5'd12;
    localparam logic [4:0] TAG_PCLK      = 5'd13;
    localparam logic [4:0] TAG_HACT      = 5'd14;
    localparam logic [4:0] TAG_HBLANK    = 5'd15;
    localparam logic [4:0] TAG_VACT      = 5'd16;
    localparam logic [4:0] TAG_VBLANK    = 5'd17;
    localparam logic [4:0] TAG_HS_OFF    = 5'd18;
    localparam logic [4:0] TAG_HS_PW     = 5'd19;
    localparam logic [4:0] TAG_VS_OFF    = 5'd20;
    localparam logic [4:0] TAG_VS_PW     = 5'd21;
    localparam logic [4:0] TAG_FLAGS     = 5'd22;
    localparam logic [4:0] TAG_MIN_V     = 5'd23;
    localparam logic [4:0] TAG_MAX_V     = 5'd24;
    localparam logic [4:0] TAG_MIN_H     = 5'd25;
    localparam logic [4:0] TAG_MAX_H     = 5'd26;
    localparam logic [4:0] TAG_MAX_PCLK  = 5'd27;
    localparam logic [4:0] TAG_DTYPE     = 5'd28;
    localparam logic [4:0] TAG_TEXT_LEN  = 5'd29;
    localparam logic [4:0] TAG_TEXT_CHAR = 5'd30;

    localparam logic [1:0] KIND_TIMING = 2'd0;
    localparam logic [1:0] KIND_RANGE  = 2'd1;
    localparam logic [1:0] KIND_OTHER  = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       block_start;
    } t_in;

    typedef struct packed {
        logic [4:0]  tag;
        logic [1:0]  desc_slot;
        logic [31:0] value;
        logic        last;
    } t_out;

    // One decode job: a finished descriptor or the block summary.
    typedef struct packed {
        logic             is_block;
        logic [1:0]       slot;
        logic             hdr_ok;
        logic             sum_ok;
        logic [17:0][7:0] data;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        return (pos == 3'd0 || pos == 3'd7) ? 8'h00 : 8'hFF;
    endfunction

    function automatic logic [7:0] vendor_letter(input logic [4:0] code);
        if (code >= 5'd1 && code <= 5'd26) begin
            return 8'h40 + {3'd0, code};
        end
        return CH_SPACE;
    endfunction

endpackage

// ----- rtl/core/edid_bp_front.sv -----
// Front end: accepts bytes, tracks position, sum and header match, and
// packages finished descriptors / block summary as jobs. Uses edid_bp_pkg.
module edid_bp_front
    import edid_bp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in       i_in,
    output logic      o_stall,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_job      o_job
);

    logic [6:0]       r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic             r_hm, n_hm;
    logic [4:0]       r_off;
    logic [1:0]       r_slot;
    logic [15:0][7:0] r_store;
    logic [17:0][7:0] r_dbuf;

    logic       acc;
    logic [6:0] pos;
    logic [7:0] b;
    logic       in_desc;
    logic [4:0] off_cur;
    logic [1:0] slot_cur;

    assign o_stall = i_q_status.full;
    assign acc     = i_valid && !o_stall;
    assign b       = i_in.byte_value;
    assign pos     = i_in.block_start ? 7'd0 : r_pos;
    assign in_desc = (pos >= POS_DESC_FIRST) && (pos <= POS_DESC_LAST);
    assign off_cur  = (pos == POS_DESC_FIRST) ? 5'd0 : r_off;
    assign slot_cur = (pos == POS_DESC_FIRST) ? 2'd0 : r_slot;

    always_comb begin
        n_pos = pos + 7'd1;
        n_sum = ((pos == 7'd0) ? 8'd0 : r_sum) + b;
        n_hm  = (pos == 7'd0) ? 1'b1 : r_hm;
        if (pos < 7'd8 && b != hdr_byte(pos[2:0])) begin
            n_hm = 1'b0;
        end
    end

    always_comb begin
        o_push        = 1'b0;
        o_job.is_block = 1'b0;
        o_job.slot    = slot_cur;
        o_job.hdr_ok  = r_hm;
        o_job.sum_ok  = (n_sum == 8'd0);
        o_job.data    = r_dbuf;
        o_job.data[17] = b;
        if (acc && pos == POS_CHECKSUM) begin
            o_push         = 1'b1;
            o_job.is_block = 1'b1;
            o_job.slot     = 2'd0;
            o_job.data     = {16'd0, r_store};
        end else if (acc && in_desc && off_cur == DESC_END_OFF) begin
            o_push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_hm   <= 1'b1;
            r_off  <= '0;
            r_slot <= '0;
        end else if (acc) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            r_hm  <= n_hm;
            if (in_desc) begin
                r_off  <= (off_cur == DESC_END_OFF) ? 5'd0 : off_cur + 5'd1;
                r_slot <= (off_cur == DESC_END_OFF) ? slot_cur + 2'd1 : slot_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (pos >= 7'd8 && pos <= 7'd22) begin
                r_store[4'(pos - 7'd8)] <= b;
            end
            if (pos == POS_EXT_COUNT) begin
                r_store[15] <= b;
            end
            if (in_desc) begin
                r_dbuf[off_cur] <= b;
            end
        end
    end

endmodule

// ----- rtl/core/edid_bp_queue.sv -----
// Small job FIFO between front and back ends.
// Uses edid_bp_pkg; DEPTH must be a power of two, at least 2.
module edid_bp_queue
    import edid_bp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_wr_data,
    input  logic      i_pop,
    output t_job      o_rd_data,
    output t_q_status o_status
);

    localparam int AW = $clog2(DEPTH);

    t_job          mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_status.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_rd_data      = mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ----- rtl/core/edid_bp_back.sv -----
// Back end: walks one job and issues its result run, one per cycle while
// i_stall is low, through an output register. Uses edid_bp_pkg.
module edid_bp_back
    import edid_bp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_valid,
    output t_out      o_out,
    input  logic      i_stall
);

    logic       r_busy;
    t_job       r_job;
    logic [3:0] r_idx;
    logic       r_ov;
    t_out       r_out;

    logic [17:0][7:0] d;
    logic [1:0]       kind;
    logic [3:0]       lastnz, len;
    logic [4:0]       cnt;
    logic [4:0]       tag;
    logic [31:0]      val;
    logic [14:0]      vendor;
    logic             adv, lst;

    assign d = r_job.data;

    always_comb begin
        if (d[0] != 8'd0 || d[1] != 8'd0) kind = KIND_TIMING;
        else if (d[3] == DT_RANGE)       kind = KIND_RANGE;
        else                             kind = KIND_OTHER;
    end

    // Text trim: drop trailing spaces, then one newline.
    always_comb begin
        lastnz = 4'd0;
        for (int j = 0; j < 13; j++) begin
            if (d[5+j] != CH_SPACE) lastnz = 4'(j + 1);
        end
        len = lastnz;
        if (lastnz != 4'd0 && d[5'd4 + {1'b0, lastnz}] == CH_NL) len = lastnz - 4'd1;
        if (!(d[3] == DT_NAME || d[3] == DT_TEXT || d[3] == DT_SERIAL)) len = 4'd0;
    end

    always_comb begin
        if (r_job.is_block)          cnt = 5'd12;
        else if (kind == KIND_TIMING) cnt = 5'd11;
        else if (kind == KIND_RANGE)  cnt = 5'd6;
        else                          cnt = 5'd3 + {1'b0, len};
    end

    always_comb begin
        if (r_job.is_block)          tag = {1'b0, r_idx};
        else if (kind == KIND_TIMING) tag = TAG_KIND + {1'b0, r_idx};
        else if (kind == KIND_RANGE) begin
            tag = (r_idx == 4'd0) ? TAG_KIND : TAG_MIN_V + {1'b0, r_idx} - 5'd1;
        end else begin
            case (r_idx)
                4'd0:    tag = TAG_KIND;
                4'd1:    tag = TAG_DTYPE;
                4'd2:    tag = TAG_TEXT_LEN;
                default: tag = TAG_TEXT_CHAR;
            endcase
        end
    end

    assign vendor = {d[0][6:0], d[1]};

    always_comb begin
        case (tag)
            TAG_HEADER_OK: val = {31'd0, r_job.hdr_ok};
            TAG_SUM_OK:    val = {31'd0, r_job.sum_ok};
            TAG_VENDOR0:   val = {24'd0, vendor_letter(vendor[14:10])};
            TAG_VENDOR1:   val = {24'd0, vendor_letter(vendor[9:5])};
            TAG_VENDOR2:   val = {24'd0, vendor_letter(vendor[4:0])};
            TAG_PRODUCT:   val = {16'd0, d[3], d[2]};
            TAG_SERIAL:    val = {d[7], d[6], d[5], d[4]};
            TAG_VERSION:   val = {24'd0, d[10]};
            TAG_REVISION:  val = {24'd0, d[11]};
            TAG_HSIZE:     val = {24'd0, d[13]};
            TAG_VSIZE:     val = {24'd0, d[14]};
            TAG_EXT_CNT:   val = {24'd0, d[15]};
            TAG_KIND:      val = {30'd0, kind};
            TAG_PCLK:      val = {16'd0, d[1], d[0]} * 32'd10;
            TAG_HACT:      val = {20'd0, d[4][7:4], d[2]};
            TAG_HBLANK:    val = {20'd0, d[4][3:0], d[3]};
            TAG_VACT:      val = {20'd0, d[7][7:4], d[5]};
            TAG_VBLANK:    val = {20'd0, d[7][3:0], d[6]};
            TAG_HS_OFF:    val = {22'd0, d[11][7:6], d[8]};
            TAG_HS_PW:     val = {22'd0, d[11][5:4], d[9]};
            TAG_VS_OFF:    val = {26'd0, d[11][3:2], d[10][7:4]};
            TAG_VS_PW:     val = {26'd0, d[11][1:0], d[10][3:0]};
            TAG_FLAGS:     val = {24'd0, d[17]};
            TAG_MIN_V:     val = {24'd0, d[5]};
            TAG_MAX_V:     val = {24'd0, d[6]};
            TAG_MIN_H:     val = {24'd0, d[7]};
            TAG_MAX_H:     val = {24'd0, d[8]};
            TAG_MAX_PCLK:  val = {24'd0, d[9]} * 32'd10000;
            TAG_DTYPE:     val = {24'd0, d[3]};
            TAG_TEXT_LEN:  val = {28'd0, len};
            TAG_TEXT_CHAR: val = {24'd0, d[5'd2 + {1'b0, r_idx}]};
            default:       val = 32'd0;
        endcase
    end

    assign adv   = !r_ov || !i_stall;
    assign lst   = ({1'b0, r_idx} + 5'd1 == cnt);
    assign o_pop = !r_busy && !i_q_status.empty;
    assign o_valid = r_ov;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && adv) begin
                if (lst) r_busy <= 1'b0;
                r_idx <= r_idx + 4'd1;
            end
            if (adv) r_ov <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (r_busy && adv) begin
            r_out.tag       <= tag;
            r_out.desc_slot <= r_job.slot;
            r_out.value     <= val;
            r_out.last      <= lst;
        end
    end

endmodule

// ----- rtl/core/edid_block_parser_top.sv -----
// EDID base block parser, top level. Front end, job queue, back end.
// Results pass the job queue, job and output registers. Throughput: one byte
// per cycle while the job queue has room; results leave one per cycle while
// i_stall is low, up to 16 per run, paced by the back end's single emitter.
// Reset (i_rst_n low, synchronous): position 0, sum 0, header match set,
// queue and output emptied. Uses edid_bp_pkg and the defines header.
`include "edid_block_parser_top_defines.svh"
module edid_block_parser_top
    import edid_bp_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_in,
    output logic o_stall,
    output logic o_valid,
    output t_out o_out,
    input  logic i_stall
);

    t_q_status q_status;
    logic      push, pop;
    t_job      wr_job, rd_job;

    edid_bp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in       (i_in),
        .o_stall    (o_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (wr_job)
    );

    edid_bp_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_job),
        .i_pop     (pop),
        .o_rd_data (rd_job),
        .o_status  (q_status)
    );

    edid_bp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (rd_job),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_stall    (i_stall)
    );

    `EBP_ASSERT_NOW(a_no_overflow, push, !q_status.full, "job queue overflow")
    `EBP_ASSERT_NOW(a_no_underflow, pop, !q_status.empty, "job queue underflow")
    `EBP_ASSERT_NOW(a_block_slot, o_valid && o_out.tag < TAG_KIND, o_out.desc_slot == 2'd0, "block result with nonzero slot")
    `EBP_ASSERT_NEXT(a_pop_fills, pop, !o_stall || q_status.full, "stall without full queue")

endmodule
